// File: hw/rtl/box_iou_unit_macros.svh
// Assertion helpers shared by the RTL; clock and reset are the module's clk and rst_n.
`ifndef BOX_IOU_UNIT_MACROS_SVH
`define BOX_IOU_UNIT_MACROS_SVH

// cond must hold in the same cycle as trig
`define BIOU_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// cond must never hold
`define BIOU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hw/rtl/biou_pkg.sv
`default_nettype none

package biou_pkg;

    // stage flags that travel with every beat down the divider row
    typedef struct packed {
        logic valid;
        logic empty;
    } biou_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/biou_front.sv
`default_nettype none

module biou_front
    import biou_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [COORD_BITS-1:0]       first_x,
    input  wire logic [COORD_BITS-1:0]       first_y,
    input  wire logic [COORD_BITS-2:0]       first_width,
    input  wire logic [COORD_BITS-2:0]       first_height,
    input  wire logic [COORD_BITS-1:0]       second_x,
    input  wire logic [COORD_BITS-1:0]       second_y,
    input  wire logic [COORD_BITS-2:0]       second_width,
    input  wire logic [COORD_BITS-2:0]       second_height,
    output biou_ctl_t                        out_ctl,
    output logic [2*COORD_BITS-3:0]          out_inter,
    output logic [2*COORD_BITS-2:0]          out_union,
    input  wire logic                        out_ready
);

    localparam int SB = COORD_BITS + 2;     // span arithmetic, signed
    localparam int AB = 2 * COORD_BITS - 2; // one box area
    localparam int UB = 2 * COORD_BITS - 1; // union area

    // stage 1: overlap spans and box areas
    logic                 v1_reg;
    logic signed [SB-1:0] ow_reg, oh_reg;
    logic [AB-1:0]        area_a_reg, area_b_reg;
    // stage 2: intersection area and area sum
    logic                 v2_reg;
    logic [AB-1:0]        inter2_reg;
    logic [UB-1:0]        sum_reg;
    // stage 3: union
    biou_ctl_t            ctl3_reg;
    logic [AB-1:0]        inter3_reg;
    logic [UB-1:0]        union_reg;

    logic rdy1, rdy2, rdy3;

    logic signed [SB-1:0] ow_next, oh_next;
    logic [AB-1:0]        area_a_next, area_b_next;
    logic [AB-1:0]        inter2_next;
    logic [UB-1:0]        sum_next;
    logic [UB-1:0]        union_next;

    function automatic logic signed [SB-1:0] span(
        input logic [COORD_BITS-1:0] lo_a,
        input logic [COORD_BITS-2:0] len_a,
        input logic [COORD_BITS-1:0] lo_b,
        input logic [COORD_BITS-2:0] len_b
    );
        logic signed [SB-1:0] la, lb, ha, hb, lo, hi;
        la = $signed({{2{lo_a[COORD_BITS-1]}}, lo_a});
        lb = $signed({{2{lo_b[COORD_BITS-1]}}, lo_b});
        ha = la + $signed({3'b000, len_a});
        hb = lb + $signed({3'b000, len_b});
        lo = (la > lb) ? la : lb;
        hi = (ha < hb) ? ha : hb;
        return hi - lo;
    endfunction

    assign rdy3     = !ctl3_reg.valid || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        ow_next     = span(first_x, first_width, second_x, second_width);
        oh_next     = span(first_y, first_height, second_y, second_height);
        area_a_next = AB'(first_width) * AB'(first_height);
        area_b_next = AB'(second_width) * AB'(second_height);
    end

    always_comb
    begin
        // a positive span is below 2^(COORD_BITS-1), so its low bits carry it
        if (!ow_reg[SB-1] && (ow_reg != '0) && !oh_reg[SB-1] && (oh_reg != '0))
        begin
            inter2_next = AB'(ow_reg[COORD_BITS-2:0]) * AB'(oh_reg[COORD_BITS-2:0]);
        end
        else
        begin
            inter2_next = '0;
        end
        sum_next = UB'(area_a_reg) + UB'(area_b_reg);
    end

    assign union_next = sum_reg - UB'(inter2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                ctl3_reg.valid <= v2_reg;
                ctl3_reg.empty <= (union_next == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ow_reg     <= ow_next;
            oh_reg     <= oh_next;
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
        end
        if (rdy2)
        begin
            inter2_reg <= inter2_next;
            sum_reg    <= sum_next;
        end
        if (rdy3)
        begin
            inter3_reg <= inter2_reg;
            union_reg  <= union_next;
        end
    end

    assign out_ctl   = ctl3_reg;
    assign out_inter = inter3_reg;
    assign out_union = union_reg;

endmodule

`default_nettype wire

// File: hw/rtl/biou_div_cell.sv
`default_nettype none

module biou_div_cell
    import biou_pkg::*;
#(
    parameter int REM_BITS = 31,
    parameter int QUO_BITS = 17
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire biou_ctl_t             in_ctl,
    input  wire logic [REM_BITS:0]     in_rem,   // partial remainder, already shifted
    input  wire logic [REM_BITS-1:0]   in_div,
    input  wire logic [QUO_BITS-1:0]   in_quo,
    output logic                       in_ready,
    output biou_ctl_t                  out_ctl,
    output logic [REM_BITS-1:0]        out_rem,
    output logic [REM_BITS-1:0]        out_div,
    output logic [QUO_BITS-1:0]        out_quo,
    input  wire logic                  out_ready
);

    biou_ctl_t             ctl_reg;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [REM_BITS-1:0]   div_reg;
    logic [QUO_BITS-1:0]   quo_reg, quo_next;
    logic [REM_BITS:0]     diff;
    logic                  take;

    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb
    begin
        diff = in_rem - {1'b0, in_div};
        take = (in_rem >= {1'b0, in_div});
        // without a subtract the remainder is below the divisor, top bit clear
        rem_next = take ? diff[REM_BITS-1:0] : in_rem[REM_BITS-1:0];
        quo_next = {in_quo[QUO_BITS-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ready)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rem_reg <= rem_next;
            div_reg <= in_div;
            quo_reg <= quo_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_rem = rem_reg;
    assign out_div = div_reg;
    assign out_quo = quo_reg;

endmodule

`default_nettype wire

// File: hw/rtl/box_iou_unit.sv
// box_iou_unit: intersection over union of two axis-aligned boxes.
//
// Input stream (s_axis_*): one beat carries both boxes, corner (x, y) signed and
// width/height unsigned; the box spans [x, x+w) by [y, y+h).
// Output stream (m_axis_*): one beat per input beat, same order. tdata holds the
// ratio as unsigned Q1.RATIO_FRAC_BITS, truncated (2^RATIO_FRAC_BITS means one);
// tuser[0] flags a zero union, in which case the ratio reads 0.
// Throughput: one pair per clock while m_axis_tready does not stall the output.
// Three stages for spans and areas, intersection and area sum, and union, then
// one divider cell per quotient bit.
// Every stage has its own valid bit and holds only while the stage after it is
// full and stalled, so bubbles close up; s_axis_tready drops only once the whole
// row of stages is full behind a stalled m_axis_tready. The last cell is the
// output register and holds its beat steady until taken.
// Reset empties every stage; no beat is in flight afterwards and no clearing
// pass is needed.
`default_nettype none

`include "box_iou_unit_macros.svh"

module box_iou_unit
    import biou_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // first_x, first_y, first_width, first_height,
    // second_x, second_y, second_width, second_height, zero pad
    input  wire logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // overlap_ratio, zero pad
    output logic [((RATIO_FRAC_BITS+1+7)/8)*8-1:0]   m_axis_tdata,
    // union_empty
    output logic [0:0]                   m_axis_tuser
);

    localparam int C      = COORD_BITS;
    localparam int F      = RATIO_FRAC_BITS;
    localparam int Q      = F + 1;
    localparam int AB     = 2 * C - 2;
    localparam int UB     = 2 * C - 1;
    localparam int OUT_W  = ((F + 1 + 7) / 8) * 8;
    localparam int OFS_FY = C;
    localparam int OFS_FW = 2 * C;
    localparam int OFS_FH = 3 * C - 1;
    localparam int OFS_SX = 4 * C - 2;
    localparam int OFS_SY = 5 * C - 2;
    localparam int OFS_SW = 6 * C - 2;
    localparam int OFS_SH = 7 * C - 3;
    localparam logic [Q-1:0] RATIO_ONE = {1'b1, {F{1'b0}}};

    biou_ctl_t        front_ctl;
    logic [AB-1:0]    front_inter;
    logic [UB-1:0]    front_union;
    logic             front_out_ready;

    biou_ctl_t        cell_ctl   [0:Q];
    logic [UB:0]      cell_rem_in[0:Q-1];
    logic [UB-1:0]    cell_rem   [1:Q];
    logic [UB-1:0]    cell_div   [0:Q];
    logic [Q-1:0]     cell_quo   [0:Q];
    logic             cell_ready [0:Q];

    logic [Q-1:0]     ratio;

    biou_front #(
        .COORD_BITS (C)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .first_x       (s_axis_tdata[C-1:0]),
        .first_y       (s_axis_tdata[OFS_FY +: C]),
        .first_width   (s_axis_tdata[OFS_FW +: C-1]),
        .first_height  (s_axis_tdata[OFS_FH +: C-1]),
        .second_x      (s_axis_tdata[OFS_SX +: C]),
        .second_y      (s_axis_tdata[OFS_SY +: C]),
        .second_width  (s_axis_tdata[OFS_SW +: C-1]),
        .second_height (s_axis_tdata[OFS_SH +: C-1]),
        .out_ctl       (front_ctl),
        .out_inter     (front_inter),
        .out_union     (front_union),
        .out_ready     (front_out_ready)
    );

    // the first cell sees the bare intersection: it never exceeds the union,
    // so its bit is the integer part of the ratio
    assign cell_ctl[0]      = front_ctl;
    assign cell_rem_in[0]   = {2'b00, front_inter};
    assign cell_div[0]      = front_union;
    assign cell_quo[0]      = '0;
    assign front_out_ready  = cell_ready[0];

    genvar k;
    generate
        for (k = 0; k < Q; k++)
        begin : g_cell
            if (k > 0)
            begin : g_shift
                assign cell_rem_in[k] = {cell_rem[k], 1'b0};
            end

            biou_div_cell #(
                .REM_BITS (UB),
                .QUO_BITS (Q)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_ctl    (cell_ctl[k]),
                .in_rem    (cell_rem_in[k]),
                .in_div    (cell_div[k]),
                .in_quo    (cell_quo[k]),
                .in_ready  (cell_ready[k]),
                .out_ctl   (cell_ctl[k+1]),
                .out_rem   (cell_rem[k+1]),
                .out_div   (cell_div[k+1]),
                .out_quo   (cell_quo[k+1]),
                .out_ready (cell_ready[k+1])
            );
        end
    endgenerate

    assign cell_ready[Q]  = m_axis_tready;
    assign ratio          = cell_ctl[Q].empty ? '0 : cell_quo[Q];
    assign m_axis_tvalid  = cell_ctl[Q].valid;
    assign m_axis_tdata   = OUT_W'(ratio);
    assign m_axis_tuser   = cell_ctl[Q].empty;

    `BIOU_ASSERT_NEVER(a_ratio_bound, m_axis_tvalid && (m_axis_tdata[Q-1:0] > RATIO_ONE),
        "overlap ratio above one")
    `BIOU_ASSERT_IMPL(a_stall_origin, !s_axis_tready, m_axis_tvalid && !m_axis_tready,
        "input back-pressure without an output stall")
    `BIOU_ASSERT_IMPL(a_rem_below_div, m_axis_tvalid && !m_axis_tuser[0],
        cell_rem[Q] < cell_div[Q], "divider remainder not below union")
    `BIOU_ASSERT_IMPL(a_empty_zero, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[Q-1:0] == '0, "zero union with non-zero ratio")

endmodule

`default_nettype wire

// File: tb/iou_checker.sv
`timescale 1ns / 100ps

module iou_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [23:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    output int           pairs_in,
    output int           results_out,
    output int           mismatches
);

    localparam int RATIO_FRAC_BITS = 16;

    typedef struct {
        logic [16:0] ratio;
        logic        empty;
    } iou_result_t;

    iou_result_t expected_iou_q[$];

    // signed length of the shared part of [lo_a, lo_a+len_a) and [lo_b, lo_b+len_b)
    function automatic longint span_overlap(longint lo_a, longint len_a,
                                            longint lo_b, longint len_b);
        longint lo;
        longint hi;
        lo = (lo_a > lo_b) ? lo_a : lo_b;
        hi = (lo_a + len_a < lo_b + len_b) ? lo_a + len_a : lo_b + len_b;
        return hi - lo;
    endfunction

    function automatic iou_result_t predict_iou(logic [123:0] beat);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint ow, oh, inter, uni;
        iou_result_t r;
        ax = $signed(beat[15:0]);
        ay = $signed(beat[31:16]);
        aw = beat[46:32];
        ah = beat[61:47];
        bx = $signed(beat[77:62]);
        by = $signed(beat[93:78]);
        bw = beat[108:94];
        bh = beat[123:109];
        ow = span_overlap(ax, aw, bx, bw);
        oh = span_overlap(ay, ah, by, bh);
        inter = (ow > 0 && oh > 0) ? ow * oh : 0;
        uni = aw * ah + bw * bh - inter;
        r.empty = (uni == 0);
        r.ratio = (uni == 0) ? 17'd0 : 17'((inter <<< RATIO_FRAC_BITS) / uni);
        return r;
    endfunction

    always @(posedge clk)
    begin
        iou_result_t want;
        int errs;
        errs = 0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_iou_q = {expected_iou_q, predict_iou(s_axis_tdata[123:0])};
                pairs_in <= pairs_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_out <= results_out + 1;
                if (expected_iou_q.size() == 0)
                begin
                    $error("result beat with no pair outstanding: overlap_ratio %0d",
                           m_axis_tdata[16:0]);
                    errs++;
                end
                else
                begin
                    want = expected_iou_q.pop_front();
                    if (m_axis_tdata[16:0] !== want.ratio)
                    begin
                        $error("overlap_ratio: expected %0d, got %0d",
                               want.ratio, m_axis_tdata[16:0]);
                        errs++;
                    end
                    if (m_axis_tuser[0] !== want.empty)
                    begin
                        $error("union_empty: expected %0d, got %0d",
                               want.empty, m_axis_tuser[0]);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY     = 20;
    localparam int N_RANDOM    = 600;
    localparam int DRAIN_LIMIT = 20000;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int pairs_in;
    int results_out;
    int mismatches;
    bit quiet_tail;
    int stall_left;
    int run_left;
    int waited;

    always #2 clk = ~clk;

    box_iou_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    iou_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pairs_in      (pairs_in),
        .results_out   (results_out),
        .mismatches    (mismatches)
    );

    // receiver: stall bursts between ready runs, some of the runs long
    always @(posedge clk)
    begin
        if (quiet_tail)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (run_left > 0)
                run_left--;
            else
            begin
                stall_left = $urandom_range(1, 8);
                run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 6);
            end
        end
    end

    // first box in the low bits, four pad bits on top
    function automatic logic [127:0] pack_pair(int fx, int fy, int fw, int fh,
                                               int sx, int sy, int sw, int sh);
        return {4'b0, sh[14:0], sw[14:0], sy[15:0], sx[15:0],
                fh[14:0], fw[14:0], fy[15:0], fx[15:0]};
    endfunction

    function automatic logic [127:0] random_pair();
        int fx, fy, fw, fh, sx, sy, sw, sh;
        fx = $urandom_range(0, 65535);
        fy = $urandom_range(0, 65535);
        fw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
        fh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
        sw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
        sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
        // second corner placed so the boxes range from apart through touching to overlapping
        sx = fx + $urandom_range(0, fw + sw + 2) - sw - 1;
        sy = fy + $urandom_range(0, fh + sh + 2) - sh - 1;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                fw = $urandom_range(0, 32767);
                fh = $urandom_range(0, 32767);
                sx = $urandom_range(0, 65535);
                sy = $urandom_range(0, 65535);
                sw = $urandom_range(0, 32767);
                sh = $urandom_range(0, 32767);
            end
            7:
            begin
                sx = fx;
                sy = fy;
                sw = fw;
                sh = fh;
            end
            8:
                case ($urandom_range(0, 4))
                    0: fw = 0;
                    1: fh = 0;
                    2: sw = 0;
                    3: sh = 0;
                    default:
                    begin
                        fw = 0;
                        sh = 0;
                    end
                endcase
            9:
            begin
                fw = $urandom_range(16384, 32767);
                fh = $urandom_range(16384, 32767);
                sw = $urandom_range(16384, 32767);
                sh = $urandom_range(16384, 32767);
                sx = fx + $urandom_range(0, 32768) - 16384;
                sy = fy + $urandom_range(0, 32768) - 16384;
            end
            default: ;
        endcase
        return pack_pair(fx, fy, fw, fh, sx, sy, sw, sh);
    endfunction

    task automatic send_pair(logic [127:0] beat);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tdata  <= beat;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        waited = 0;
        @(posedge clk);
        while (pairs_in != results_out && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both boxes empty, and zero area in only one dimension each
        send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(-32768, 32767, 0, 32767, 32767, -32768, 32767, 0));
        // identical boxes, small and at the extremes
        send_pair(pack_pair(0, 0, 10, 10, 0, 0, 10, 10));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_pair(pack_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pack_pair(-1, -1, 32767, 32767, -1, -1, 32767, 32767));
        // zero-area box inside a non-empty one
        send_pair(pack_pair(2, 2, 0, 5, 0, 0, 10, 10));
        send_pair(pack_pair(0, 0, 10, 10, 3, 3, 4, 0));
        // touching in x, in y and at a corner, then disjoint
        send_pair(pack_pair(0, 0, 10, 10, 10, 0, 10, 10));
        send_pair(pack_pair(0, 0, 10, 10, 0, 10, 10, 10));
        send_pair(pack_pair(10, 10, 5, 5, 0, 0, 10, 10));
        send_pair(pack_pair(-32768, -32768, 100, 100, 32767, 32767, 100, 100));
        // partial overlap, containment, overlap across zero
        send_pair(pack_pair(0, 0, 10, 10, 5, 5, 10, 10));
        send_pair(pack_pair(0, 0, 100, 100, 10, 10, 10, 10));
        send_pair(pack_pair(-5, -5, 10, 10, 0, 0, 10, 10));
        // one pixel shared by two huge boxes: the ratio truncates to zero
        send_pair(pack_pair(-32768, -32768, 32767, 32767, -2, -2, 32767, 32767));
        // right edge past the 16-bit range
        send_pair(pack_pair(32000, 0, 32767, 1, 32700, 0, 32767, 1));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                // hold off until everything in flight has come back
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            if (i == N_RANDOM - 80)
                quiet_tail = 1'b1;
            send_pair(random_pair());
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);

        $display("Checked %0d box pairs (edge cases, then random) and %0d result beats.",
                 pairs_in, results_out);
        $display("Gaps and stalls in bursts on both sides, one full drain mid-run, clean tail.");
        if (mismatches == 0 && pairs_in == results_out)
            $display("PASS box_iou_unit");
        else
            $display("FAIL box_iou_unit");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Run did not complete in time: %0d pairs in, %0d results out.",
                 pairs_in, results_out);
        $display("FAIL box_iou_unit");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/biou_pkg.sv
hw/rtl/biou_front.sv
hw/rtl/biou_div_cell.sv
hw/rtl/box_iou_unit.sv
tb/iou_checker.sv
tb/tb_top.sv
